### sv/tlps_pkg.sv
//------------------------------------------------------------------------------
// tlps_pkg: shared types and constants
// Payload structs, sequencer states and sizing for the aging scheduler.
//------------------------------------------------------------------------------
package tlps_pkg;
  localparam int Slots = 8;
  localparam int IdW   = 3;
  localparam int CntW  = 4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadPrio = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  localparam logic CmdAdd   = 1'b0;
  localparam logic CmdSched = 1'b1;

  localparam logic [7:0] ThreshReset = 8'd10;
  localparam logic [7:0] WaitMax     = 8'd255;

  typedef struct packed {
    logic       cmd;
    logic [1:0] priority_req;
    logic       old_valid;
    logic [2:0] old_thread_id;
  } tlps_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       next_valid;
    logic [2:0] next_thread_id;
    logic       by_starvation;
  } tlps_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_PICK, S_AGE, S_RMRD, S_RMWR, S_REQ, S_OUT
  } tlps_state_t;
endpackage

### sv/tlps_ram.sv
//------------------------------------------------------------------------------
// tlps_ram: generic simple dual-port synchronous RAM
// One write and one registered read per cycle.
//------------------------------------------------------------------------------
module tlps_ram #(
  parameter int Depth = 8,
  parameter int Width = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/two_level_priority_scheduler_aging.sv
//------------------------------------------------------------------------------
// two_level_priority_scheduler_aging: two-queue thread scheduler with aging
// Channel | dir | handshake         | payload
// in      | in  | in_valid/in_stall | tlps_in_t
// out     | out | out_valid/out_stall| tlps_out_t
// cfg     | in  | APB write/read    | aging threshold @ 0x0
// Add: result valid the cycle after the request is taken.
// Schedule with N threads: N-slot starvation scan, pick, N-slot aging sweep,
// requeue. A starvation hit skips pick and sweep, removing the thread
// from its queue (shifting one entry per cycle); empty queues end at the pick.
// Reset clears counters and heads; memories need no clearing pass.
// One request in flight; in_stall high until the result is taken.
//------------------------------------------------------------------------------
module two_level_priority_scheduler_aging import tlps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tlps_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tlps_out_t out_data,
  input  logic      cfg_psel,
  input  logic      cfg_penable,
  input  logic      cfg_pwrite,
  input  logic      cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic      cfg_pready
);
  logic [7:0] thresh_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr ? 32'd0 : {24'd0, thresh_r};
  always_ff @(posedge clk) begin
    if (!rst_n) thresh_r <= ThreshReset;
    else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr)
      thresh_r <= cfg_pwdata[7:0];
  end

  // small per-slot priority bits and queue rams kept in flops (fixed reads)
  logic [Slots-1:0] prio_r;
  logic [IdW-1:0] hq_r [Slots];
  logic [IdW-1:0] lq_r [Slots];
  logic [IdW-1:0] hhead_r, lhead_r;
  logic [CntW-1:0] hcnt_r, lcnt_r, added_r;

  tlps_state_t st_r, st_nxt;
  tlps_in_t    req_r;
  tlps_out_t   res_r;
  logic        ov_r;
  logic [CntW-1:0] idx_r;     // scan index
  logic [IdW-1:0]  pick_r;
  logic            starv_r;
  logic            rmhi_r;
  logic [CntW-1:0] rmi_r;
  logic            rmfound_r;

  // wait counters live in a RAM
  logic        w_we;
  logic [IdW-1:0] w_wa, w_ra;
  logic [7:0]  w_wd, w_rd;
  tlps_ram #(.Depth(Slots), .Width(8)) u_wait (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));

  assign in_stall  = (st_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  logic [IdW-1:0] rd_slot_r;  // slot whose data is on w_rd
  logic           rd_v_r;
  logic [CntW-1:0] idx_p1;
  assign idx_p1 = idx_r + 1'b1;
  // both sweeps start at slot 0, issued from idle and from the pick cycle
  assign w_ra = (st_r == S_IDLE || st_r == S_PICK) ? '0 : idx_r[IdW-1:0];

  logic [IdW-1:0] rmq_a, rmq_b;
  always_comb begin
    rmq_a = rmhi_r ? hhead_r + rmi_r[IdW-1:0] : lhead_r + rmi_r[IdW-1:0];
    rmq_b = rmq_a + 1'b1;
  end
  logic [IdW-1:0] rm_ent;
  assign rm_ent = rmhi_r ? hq_r[rmq_a] : lq_r[rmq_a];
  logic [CntW-1:0] rm_cnt;
  assign rm_cnt = rmhi_r ? hcnt_r : lcnt_r;

  logic req_ok;
  assign req_ok = req_r.old_valid && ({1'b0, req_r.old_thread_id} < added_r);

  // next state and wait-counter write port
  always_comb begin
    st_nxt = st_r;
    w_we = 1'b0; w_wa = rd_slot_r; w_wd = 8'd0;
    case (st_r)
      S_IDLE: if (in_valid && !in_stall) begin
        if (in_data.cmd == CmdSched) begin
          st_nxt = (added_r != '0) ? S_SCAN : S_PICK;
        end else if (!in_data.priority_req[1] && added_r != CntW'(Slots)) begin
          w_we = 1'b1; w_wa = added_r[IdW-1:0]; w_wd = 8'd0;
        end
      end
      S_SCAN: begin
        if (rd_v_r && w_rd >= thresh_r) begin
          w_we = 1'b1; w_wd = 8'd0;
          st_nxt = S_RMRD;
        end else if (idx_r >= added_r) st_nxt = S_PICK;
      end
      S_PICK: st_nxt = (hcnt_r != '0 || lcnt_r != '0) ? S_AGE : S_IDLE;
      S_AGE: begin
        if (rd_v_r) begin
          w_we = 1'b1;
          w_wd = (rd_slot_r == pick_r) ? 8'd0 :
                 (w_rd == WaitMax) ? w_rd : w_rd + 8'd1;
        end
        if (idx_r >= added_r) st_nxt = S_REQ;
      end
      S_RMRD: begin
        if (rmi_r >= rm_cnt) st_nxt = S_REQ;
        else if (rmfound_r || rm_ent == pick_r) st_nxt = S_RMWR;
      end
      S_RMWR: if (!(rmi_r + 1'b1 < rm_cnt)) st_nxt = S_REQ;
      S_REQ: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; hhead_r <= '0; lhead_r <= '0;
      hcnt_r <= '0; lcnt_r <= '0; added_r <= '0; rd_v_r <= 1'b0; idx_r <= '0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          rd_v_r <= in_valid && !in_stall && in_data.cmd == CmdSched && added_r != '0;
          if (in_valid && !in_stall) begin
            req_r <= in_data;
            if (in_data.cmd == CmdAdd) begin
              if (in_data.priority_req[1]) begin
                res_r <= '{status: StBadPrio, next_valid: 1'b0, next_thread_id: '0,
                           by_starvation: 1'b0};
                ov_r <= 1'b1;
              end else if (added_r == CntW'(Slots)) begin
                res_r <= '{status: StFull, next_valid: 1'b0, next_thread_id: '0,
                           by_starvation: 1'b0};
                ov_r <= 1'b1;
              end else begin
                prio_r[added_r[IdW-1:0]] <= in_data.priority_req[0];
                if (in_data.priority_req[0]) begin
                  if (hcnt_r != CntW'(Slots)) begin
                    hq_r[hhead_r + hcnt_r[IdW-1:0]] <= added_r[IdW-1:0];
                    hcnt_r <= hcnt_r + 1'b1;
                  end
                end else if (lcnt_r != CntW'(Slots)) begin
                  lq_r[lhead_r + lcnt_r[IdW-1:0]] <= added_r[IdW-1:0];
                  lcnt_r <= lcnt_r + 1'b1;
                end
                added_r <= added_r + 1'b1;
                res_r <= '{status: StOk, next_valid: 1'b1,
                           next_thread_id: added_r[IdW-1:0], by_starvation: 1'b0};
                ov_r <= 1'b1;
              end
            end else begin
              res_r <= '0; starv_r <= 1'b0; rd_slot_r <= '0;
              idx_r <= (added_r != '0) ? CntW'(1) : '0;
            end
          end
        end
        S_SCAN: begin
          if (rd_v_r && w_rd >= thresh_r) begin
            starv_r <= 1'b1; pick_r <= rd_slot_r;
            rmhi_r <= prio_r[rd_slot_r]; rmi_r <= '0; rmfound_r <= 1'b0;
            rd_v_r <= 1'b0;
          end else if (idx_r < added_r) begin
            rd_v_r <= 1'b1; rd_slot_r <= idx_r[IdW-1:0]; idx_r <= idx_p1;
          end else rd_v_r <= 1'b0;
        end
        S_PICK: begin
          if (hcnt_r != '0) begin
            pick_r <= hq_r[hhead_r]; hhead_r <= hhead_r + 1'b1;
            hcnt_r <= hcnt_r - 1'b1;
            rd_v_r <= 1'b1; rd_slot_r <= '0; idx_r <= CntW'(1);
          end else if (lcnt_r != '0) begin
            pick_r <= lq_r[lhead_r]; lhead_r <= lhead_r + 1'b1;
            lcnt_r <= lcnt_r - 1'b1;
            rd_v_r <= 1'b1; rd_slot_r <= '0; idx_r <= CntW'(1);
          end else begin
            res_r <= '{status: StOk, next_valid: req_r.old_valid,
                       next_thread_id: req_r.old_valid ? req_r.old_thread_id : '0,
                       by_starvation: 1'b0};
            ov_r <= 1'b1; rd_v_r <= 1'b0;
          end
        end
        S_AGE: begin
          if (idx_r < added_r) begin
            rd_v_r <= 1'b1; rd_slot_r <= idx_r[IdW-1:0]; idx_r <= idx_p1;
          end else rd_v_r <= 1'b0;
        end
        S_RMRD: begin
          // find first occurrence, then shift later entries forward
          rd_v_r <= 1'b0;
          if (rmi_r < rm_cnt) begin
            if (rmfound_r || rm_ent == pick_r) rmfound_r <= 1'b1;
            else rmi_r <= rmi_r + 1'b1;
          end
        end
        S_RMWR: begin
          rd_v_r <= 1'b0;
          if (rmi_r + 1'b1 < rm_cnt) begin
            if (rmhi_r) hq_r[rmq_a] <= hq_r[rmq_b];
            else lq_r[rmq_a] <= lq_r[rmq_b];
            rmi_r <= rmi_r + 1'b1;
          end else begin
            if (rmhi_r) hcnt_r <= hcnt_r - 1'b1;
            else lcnt_r <= lcnt_r - 1'b1;
          end
        end
        S_REQ: begin
          rd_v_r <= 1'b0;
          if (req_ok) begin
            if (prio_r[req_r.old_thread_id]) begin
              if (hcnt_r != CntW'(Slots)) begin
                hq_r[hhead_r + hcnt_r[IdW-1:0]] <= req_r.old_thread_id;
                hcnt_r <= hcnt_r + 1'b1;
              end
            end else if (lcnt_r != CntW'(Slots)) begin
              lq_r[lhead_r + lcnt_r[IdW-1:0]] <= req_r.old_thread_id;
              lcnt_r <= lcnt_r + 1'b1;
            end
          end
          res_r <= '{status: StOk, next_valid: 1'b1, next_thread_id: pick_r,
                     by_starvation: starv_r};
          ov_r <= 1'b1;
        end
        default: rd_v_r <= 1'b0;
      endcase
    end
  end
endmodule

### sv/tlps_checker.sv
//------------------------------------------------------------------------------
// tlps_checker: port-level checks
// Watches handshakes and result codes at the top level.
//------------------------------------------------------------------------------
module tlps_checker import tlps_pkg::*; (
  input logic clk, input logic rst_n,
  input logic in_stall,
  input logic out_valid, input logic out_stall,
  input tlps_out_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accepted while result pending");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != StOk |-> !out_data.next_valid)
    else $error("reject with valid id");
  a_starv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.by_starvation |-> out_data.next_valid &&
    out_data.status == StOk) else $error("bad starvation result");
endmodule

bind two_level_priority_scheduler_aging tlps_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

### test/testbench.sv
//------------------------------------------------------------------------------
// testbench: self-checking bench for two_level_priority_scheduler_aging
// Table-driven directed requests, then random schedule traffic over several
// starvation thresholds. Results are checked in queue order against a local
// model or a typed row's want; random stalls on both sides, one long hold-off.
//------------------------------------------------------------------------------
module testbench;
  import tlps_pkg::*;

  localparam int IdleLimit = 5000;  // cycles with no handshake before giving up
  localparam int Drain     = 40;    // worst-case schedule latency, rounded up
  localparam int PhaseLen  = 240;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tlps_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  tlps_out_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic        cfg_paddr = 1'b0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always #5 clk = ~clk;

  two_level_priority_scheduler_aging u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  // ---------------------------------------------------------------------------
  // Scheduler model state. Ready queues indexed by level: 1 high, 0 low.
  // ---------------------------------------------------------------------------
  logic [2:0] ready_q[2][Slots];
  int         ready_head[2];
  int         ready_cnt[2];
  logic [7:0] wait_cnt[Slots];
  logic       thread_hi[Slots];
  int         threads_added;
  logic [7:0] thresh;

  tlps_out_t  sched_expect_q[$];
  int         errors = 0;
  int         requests_taken = 0;
  bit         calm = 1'b0;        // no idling on either side while set
  bit         running_valid = 1'b0;
  logic [2:0] running_id = '0;

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void ready_push(int lvl, logic [2:0] id);
    if (ready_cnt[lvl] >= Slots) return;  // full queue drops the requeue
    ready_q[lvl][(ready_head[lvl] + ready_cnt[lvl]) % Slots] = id;
    ready_cnt[lvl]++;
  endfunction

  // Remove first occurrence, shifting the tail up by one.
  function automatic void ready_remove(int lvl, logic [2:0] id);
    int i;
    int j;
    for (i = 0; i < ready_cnt[lvl]; i++) begin
      if (ready_q[lvl][(ready_head[lvl] + i) % Slots] == id) begin
        for (j = i; j + 1 < ready_cnt[lvl]; j++)
          ready_q[lvl][(ready_head[lvl] + j) % Slots] =
            ready_q[lvl][(ready_head[lvl] + j + 1) % Slots];
        ready_cnt[lvl]--;
        return;
      end
    end
  endfunction

  // Outgoing thread goes back only if it was ever registered.
  function automatic void requeue_outgoing(logic ov, logic [2:0] id);
    if (!ov || id >= threads_added) return;
    ready_push(thread_hi[id] ? 1 : 0, id);
  endfunction

  function automatic tlps_out_t sched_predict(tlps_in_t d);
    tlps_out_t r;
    int i;
    int lvl;
    logic [2:0] pick;
    r = '0;
    if (d.cmd == CmdAdd) begin
      // bad priority wins over a full table
      if (d.priority_req > 2'd1) begin
        r.status = StBadPrio;
        return r;
      end
      if (threads_added >= Slots) begin
        r.status = StFull;
        return r;
      end
      wait_cnt[threads_added] = '0;
      thread_hi[threads_added] = d.priority_req[0];
      ready_push(d.priority_req[0] ? 1 : 0, threads_added[2:0]);
      r.next_valid = 1'b1;
      r.next_thread_id = threads_added[2:0];
      threads_added++;
      return r;
    end
    // aging override: lowest starved slot wins, other counters untouched
    for (i = 0; i < threads_added; i++) begin
      if (wait_cnt[i] >= thresh) begin
        wait_cnt[i] = '0;
        ready_remove(thread_hi[i] ? 1 : 0, i[2:0]);
        requeue_outgoing(d.old_valid, d.old_thread_id);
        r.next_valid = 1'b1;
        r.next_thread_id = i[2:0];
        r.by_starvation = 1'b1;
        return r;
      end
    end
    if (ready_cnt[1] > 0) lvl = 1;
    else if (ready_cnt[0] > 0) lvl = 0;
    else begin
      // nothing ready: keep running the outgoing thread
      r.next_valid = d.old_valid;
      r.next_thread_id = d.old_valid ? d.old_thread_id : 3'd0;
      return r;
    end
    pick = ready_q[lvl][ready_head[lvl]];
    ready_head[lvl] = (ready_head[lvl] + 1) % Slots;
    ready_cnt[lvl]--;
    for (i = 0; i < threads_added; i++) begin
      if (i == pick) wait_cnt[i] = '0;
      else if (wait_cnt[i] < WaitMax) wait_cnt[i] = wait_cnt[i] + 8'd1;
    end
    requeue_outgoing(d.old_valid, d.old_thread_id);
    r.next_valid = 1'b1;
    r.next_thread_id = pick;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Valid is lowered only to idle, to quiesce, or at the end.
  // ---------------------------------------------------------------------------
  task automatic send_request(tlps_in_t d, bit typed, tlps_out_t want);
    tlps_out_t p;
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    p = sched_predict(d);
    sched_expect_q.push_back(typed ? want : p);
    requests_taken++;
    if (d.cmd == CmdSched) begin
      running_valid = p.next_valid;
      running_id    = p.next_thread_id;
    end
  endtask

  task automatic cfg_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= 1'b0;   // the threshold is the only register
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_thresh();
    logic [31:0] rd;
    cfg_access(1'b0, '0, rd);
    if (rd[7:0] !== thresh) report("threshold readback", int'(rd[7:0]), int'(thresh));
  endtask

  function automatic tlps_in_t random_request();
    tlps_in_t d;
    logic [31:0] rnd;
    int r;
    rnd = $urandom;
    d = tlps_in_t'(rnd[$bits(tlps_in_t)-1:0]);
    r = $urandom_range(99);
    if (r < 8) d.cmd = CmdAdd;
    else begin
      d.cmd = CmdSched;
      // mostly a proper context switch: the running thread goes out
      if (r < 80 && running_valid) begin
        d.old_valid = 1'b1;
        d.old_thread_id = running_id;
      end
    end
    return d;
  endfunction

  // Directed stimulus table
  typedef struct {
    tlps_in_t  d;
    bit        typed;
    tlps_out_t want;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic void row(logic cmd, logic [1:0] pr, logic ov, logic [2:0] oid,
                              bit typed, logic [1:0] st, logic nv, logic [2:0] nid);
    dir_row_t x;
    x.d = '{cmd: cmd, priority_req: pr, old_valid: ov, old_thread_id: oid};
    x.typed = typed;
    x.want = '{status: st, next_valid: nv, next_thread_id: nid, by_starvation: 1'b0};
    dir_rows.push_back(x);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tlps_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (sched_expect_q.size() == 0) report("unexpected result", int'(out_data), 0);
      else begin
        e = sched_expect_q.pop_front();
        if (out_data.status !== e.status)
          report("status", int'(out_data.status), int'(e.status));
        if (out_data.next_valid !== e.next_valid)
          report("next_valid", int'(out_data.next_valid), int'(e.next_valid));
        if (out_data.next_thread_id !== e.next_thread_id)
          report("next_thread_id", int'(out_data.next_thread_id),
                 int'(e.next_thread_id));
        if (out_data.by_starvation !== e.by_starvation)
          report("by_starvation", int'(out_data.by_starvation), int'(e.by_starvation));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side stall: random, plus one long hold-off once traffic is going
  // so the single in-flight request backs up into in_stall.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && requests_taken >= 300) begin
        held = 1'b1;
        hold_left = 400;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 7);
      end
    end
  end

  // Watchdog: cycles with no handshake of any kind
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("FAIL two_level_priority_scheduler_aging");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [7:0] thresh_list[6] = '{8'd1, 8'd255, 8'd2, 8'd40, 8'd5, 8'd10};

  initial begin
    logic [31:0] rd;
    ready_head    = '{0, 0};
    ready_cnt     = '{0, 0};
    threads_added = 0;
    thresh        = ThreshReset;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_thresh();

    // empty queues hand back the outgoing thread, unregistered or not
    row(CmdSched, 2'd0, 1'b1, 3'd5, 1, StOk, 1'b1, 3'd5);
    row(CmdSched, 2'd3, 1'b0, 3'd7, 1, StOk, 1'b0, 3'd0);
    row(CmdAdd,   2'd2, 1'b0, 3'd0, 1, StBadPrio, 1'b0, 3'd0);
    row(CmdAdd,   2'd3, 1'b1, 3'd7, 1, StBadPrio, 1'b0, 3'd0);
    // fill the table, ids handed out in add order
    row(CmdAdd,   2'd1, 1'b1, 3'd7, 1, StOk, 1'b1, 3'd0);
    row(CmdAdd,   2'd0, 1'b0, 3'd0, 1, StOk, 1'b1, 3'd1);
    row(CmdSched, 2'd0, 1'b0, 3'd0, 0, StOk, 1'b0, 3'd0);
    row(CmdAdd,   2'd1, 1'b0, 3'd0, 1, StOk, 1'b1, 3'd2);
    row(CmdAdd,   2'd0, 1'b0, 3'd0, 1, StOk, 1'b1, 3'd3);
    row(CmdAdd,   2'd1, 1'b0, 3'd0, 1, StOk, 1'b1, 3'd4);
    row(CmdAdd,   2'd0, 1'b0, 3'd0, 1, StOk, 1'b1, 3'd5);
    row(CmdAdd,   2'd1, 1'b0, 3'd0, 1, StOk, 1'b1, 3'd6);
    row(CmdAdd,   2'd0, 1'b0, 3'd0, 1, StOk, 1'b1, 3'd7);
    // table full, and full plus bad priority
    row(CmdAdd,   2'd0, 1'b0, 3'd0, 1, StFull, 1'b0, 3'd0);
    row(CmdAdd,   2'd1, 1'b1, 3'd7, 1, StFull, 1'b0, 3'd0);
    row(CmdAdd,   2'd3, 1'b0, 3'd0, 1, StBadPrio, 1'b0, 3'd0);
    row(CmdSched, 2'd0, 1'b1, 3'd0, 0, StOk, 1'b0, 3'd0);
    row(CmdSched, 2'd0, 1'b1, 3'd7, 0, StOk, 1'b0, 3'd0);
    row(CmdSched, 2'd0, 1'b1, 3'd1, 0, StOk, 1'b0, 3'd0);
    row(CmdSched, 2'd0, 1'b0, 3'd3, 0, StOk, 1'b0, 3'd0);
    row(CmdSched, 2'd0, 1'b1, 3'd2, 0, StOk, 1'b0, 3'd0);

    foreach (dir_rows[i]) send_request(dir_rows[i].d, dir_rows[i].typed, dir_rows[i].want);

    foreach (thresh_list[p]) begin
      // quiesce before touching the threshold
      in_valid <= 1'b0;
      while (sched_expect_q.size() != 0) @(posedge clk);
      repeat (Drain) @(posedge clk);
      cfg_access(1'b1, {24'd0, thresh_list[p]}, rd);
      thresh = thresh_list[p];
      @(posedge clk);
      check_thresh();
      for (int n = 0; n < PhaseLen; n++) begin
        calm = (p == 3) && (n < 150);
        send_request(random_request(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (sched_expect_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
    if (errors == 0) $display("PASS two_level_priority_scheduler_aging");
    else $display("FAIL two_level_priority_scheduler_aging");
    $finish;
  end
endmodule
